// ===== rtl/spc_pkg.sv =====
package spc_pkg;

	// field and register widths
	localparam int COUNT_BITS      = 16;
	localparam int SHIFT_BITS      = 4;
	localparam int COLOR_BITS      = 8;
	localparam int PIXEL_BITS      = 3 * COLOR_BITS;
	localparam int CFG_INDEX_BITS  = 1;
	localparam int CFG_DATA_BITS   = 16;
	localparam int MAX_ITER_RESET  = 100;

	// fixed-point formats
	localparam int PHASE_FRACTION_BITS = 16;
	localparam int SINE_TABLE_DEPTH    = 1024;
	localparam int SINE_ADDR_BITS      = $clog2(SINE_TABLE_DEPTH);
	localparam int QUARTER_DEPTH       = SINE_TABLE_DEPTH / 4;
	localparam int QUARTER_BITS        = SINE_ADDR_BITS - 2;
	localparam int DIV_STEPS           = COUNT_BITS + PHASE_FRACTION_BITS;
	localparam int REM_BITS            = COUNT_BITS + 1;
	localparam int NUM_CHANNELS        = 3;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [PHASE_FRACTION_BITS-1:0] phase_t;
	typedef logic [COLOR_BITS-1:0]          color_t;
	typedef phase_t                         shift_rom_t [1 << SHIFT_BITS];
	typedef color_t                         sine_rom_t [QUARTER_DEPTH];

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_MAX_ITER      = 1'b0,
		CFG_PALETTE_SHIFT = 1'b1
	} cfg_reg_t;

	// quarter turn and the green/blue channel offsets, in turns
	localparam phase_t QUARTER_TURN = phase_t'(64'd1 << (PHASE_FRACTION_BITS - 2));
	localparam phase_t GREEN_OFFSET =
		phase_t'(((64'd3333 << PHASE_FRACTION_BITS) + 64'd5000) / 64'd10000);
	localparam phase_t BLUE_OFFSET =
		phase_t'(((64'd6666 << PHASE_FRACTION_BITS) + 64'd5000) / 64'd10000);

	// shift * 0.1 turn, rounded, kept modulo one turn
	function automatic shift_rom_t build_shift_rom();
		shift_rom_t rom;
		for (int i = 0; i < (1 << SHIFT_BITS); i++) begin
			rom[i] = phase_t'(((64'(i) << PHASE_FRACTION_BITS) + 64'd5) / 64'd10);
		end
		return rom;
	endfunction

	localparam shift_rom_t SHIFT_ROM = build_shift_rom();

	// taylor term step: divide by (k+1)*(k+2)
	function automatic logic [63:0] series_div(logic [63:0] v, int k);
		logic [63:0] res;
		case (k)
			1:       res = v / 64'd6;
			3:       res = v / 64'd20;
			5:       res = v / 64'd42;
			7:       res = v / 64'd72;
			9:       res = v / 64'd110;
			11:      res = v / 64'd156;
			13:      res = v / 64'd210;
			15:      res = v / 64'd272;
			17:      res = v / 64'd342;
			19:      res = v / 64'd420;
			21:      res = v / 64'd506;
			23:      res = v / 64'd600;
			25:      res = v / 64'd702;
			27:      res = v / 64'd812;
			29:      res = v / 64'd930;
			31:      res = v / 64'd1056;
			33:      res = v / 64'd1190;
			35:      res = v / 64'd1332;
			37:      res = v / 64'd1482;
			39:      res = v / 64'd1640;
			default: res = 64'd0;
		endcase
		return res;
	endfunction

	// sin(num/depth * pi/2) in q30, clamped to [0, 1]
	function automatic logic [63:0] quarter_sine(logic [63:0] num);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		bit          neg;
		bit          active;
		x      = (num * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
		x2     = (x * x) >> 30;
		term   = x;
		sum    = 0;
		neg    = 1'b0;
		active = 1'b1;
		for (int k = 1; k < 40; k += 2) begin
			if (active) begin
				if (term == 64'd0) begin
					active = 1'b0;
				end else begin
					if (neg)
						sum = sum - longint'(term);
					else
						sum = sum + longint'(term);
					term = series_div((term * x2) >> 30, k);
					neg  = !neg;
				end
			end
		end
		if (sum < 0)
			sum = 0;
		if (sum > longint'(Q30_ONE))
			sum = longint'(Q30_ONE);
		return 64'(sum);
	endfunction

	// palette entry for quarter-wave argument a, negated half when neg
	function automatic color_t sine_entry(int unsigned a, bit neg);
		longint      s;
		logic [63:0] v;
		s = longint'(quarter_sine(64'(a) * 64'd4));
		if (neg)
			s = -s;
		v = (64'(s + longint'(Q30_ONE)) * 64'd255) >> 31;
		if (v > 64'd255)
			v = 64'd255;
		return color_t'(v);
	endfunction

	function automatic sine_rom_t build_sine_rom(bit neg);
		sine_rom_t rom;
		for (int a = 0; a < QUARTER_DEPTH; a++) begin
			rom[a] = sine_entry(a, neg);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_POS_ROM  = build_sine_rom(1'b0);
	localparam sine_rom_t SINE_NEG_ROM  = build_sine_rom(1'b1);
	localparam color_t    SINE_POS_PEAK = sine_entry(QUARTER_DEPTH, 1'b0);
	localparam color_t    SINE_NEG_PEAK = sine_entry(QUARTER_DEPTH, 1'b1);

endpackage

// ===== rtl/sine_palette_colorizer.sv =====
// channel  | signals                                  | direction | transfer when
// ---------+------------------------------------------+-----------+----------------------
// input    | in_valid, in_stall, iteration_count      | in        | in_valid & !in_stall
// output   | out_valid, out_stall, pixel_color        | out       | out_valid & !out_stall
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | cfg_valid & cfg_ready
//
// one pixel per clock sustained while the output is not stalled; an input register feeds
// the bit-per-stage restoring divider for count / max_iterations, then phase, address, color.
// arst_n clears all valid bits and loads max_iterations = 100, palette_shift = 0.
// the whole pipe holds, bubbles included, while the output register is full and stalled;
// in_stall is high in exactly those cycles. config is taken every cycle (cfg_ready = 1).
module sine_palette_colorizer import spc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [COUNT_BITS-1:0]      iteration_count,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [PIXEL_BITS-1:0]      pixel_color,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [COUNT_BITS-1:0] max_iter_q;
	logic [SHIFT_BITS-1:0] shift_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= COUNT_BITS'(MAX_ITER_RESET);
			shift_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MAX_ITER:      max_iter_q <= cfg_data[COUNT_BITS-1:0];
				CFG_PALETTE_SHIFT: shift_q    <= cfg_data[SHIFT_BITS-1:0];
				default:           ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline advance: everything moves unless a finished pixel is stuck
	// ------------------------------------------------------------------
	logic adv;
	logic col_vld_s;

	assign adv      = !(col_vld_s && out_stall);
	assign in_stall = !adv;

	// ------------------------------------------------------------------
	// divider: entry 0 is the input register, entry k+1 holds the result
	// of quotient bit k. dividend is count << fraction bits, only the low
	// fraction bits of the quotient survive (ratio taken modulo one turn)
	// ------------------------------------------------------------------
	logic                  div_vld_s [DIV_STEPS+1];
	logic                  div_blk_s [DIV_STEPS+1];
	logic [COUNT_BITS-1:0] div_cnt_s [DIV_STEPS+1];
	logic [COUNT_BITS-1:0] div_rem_s [DIV_STEPS+1];
	phase_t                div_quo_s [DIV_STEPS+1];

	logic [COUNT_BITS-1:0] div_rem_nx [DIV_STEPS];
	phase_t                div_quo_nx [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic                dbit;
		logic [REM_BITS-1:0] trial;
		logic                ge;

		// upper dividend bits come from the count, the rest are zero
		if (k < COUNT_BITS) begin : g_hi
			assign dbit = div_cnt_s[k][COUNT_BITS-1-k];
		end else begin : g_lo
			assign dbit = 1'b0;
		end

		assign trial         = {div_rem_s[k], dbit};
		assign ge            = trial >= {1'b0, max_iter_q};
		assign div_rem_nx[k] = ge ? COUNT_BITS'(trial - {1'b0, max_iter_q})
		                          : trial[COUNT_BITS-1:0];
		assign div_quo_nx[k] = {div_quo_s[k][PHASE_FRACTION_BITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++) begin
				div_vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			div_vld_s[0] <= in_valid;
			for (int k = 0; k < DIV_STEPS; k++) begin
				div_vld_s[k+1] <= div_vld_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// interior pixel flagged at entry, rendered black at the end
			div_blk_s[0] <= (iteration_count == max_iter_q);
			div_cnt_s[0] <= iteration_count;
			div_rem_s[0] <= '0;
			div_quo_s[0] <= '0;
			for (int k = 0; k < DIV_STEPS; k++) begin
				div_blk_s[k+1] <= div_blk_s[k];
				div_cnt_s[k+1] <= div_cnt_s[k];
				div_rem_s[k+1] <= div_rem_nx[k];
				div_quo_s[k+1] <= div_quo_nx[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// phase stage: t = ratio + shift*0.1 + 0.25, then the channel offsets
	// ------------------------------------------------------------------
	phase_t ratio;
	phase_t t_base;
	logic   ph_vld_s;
	logic   ph_blk_s;
	phase_t ph_phase_s [NUM_CHANNELS];

	// a zero limit (outside the legal range) gives a ratio of zero
	assign ratio  = (max_iter_q == '0) ? '0 : div_quo_s[DIV_STEPS];
	assign t_base = ratio + SHIFT_ROM[shift_q] + QUARTER_TURN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ph_vld_s <= 1'b0;
		else if (adv)
			ph_vld_s <= div_vld_s[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_blk_s      <= div_blk_s[DIV_STEPS];
			ph_phase_s[0] <= t_base;
			ph_phase_s[1] <= t_base + GREEN_OFFSET;
			ph_phase_s[2] <= t_base + BLUE_OFFSET;
		end
	end

	// ------------------------------------------------------------------
	// address stage: nearest table index, folded onto a quarter wave
	// ------------------------------------------------------------------
	logic                    ad_vld_s;
	logic                    ad_blk_s;
	logic [QUARTER_BITS-1:0] ad_addr_s [NUM_CHANNELS];
	logic                    ad_neg_s  [NUM_CHANNELS];
	logic                    ad_peak_s [NUM_CHANNELS];

	logic [QUARTER_BITS-1:0] ad_addr_nx [NUM_CHANNELS];
	logic                    ad_neg_nx  [NUM_CHANNELS];
	logic                    ad_peak_nx [NUM_CHANNELS];

	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_addr
		logic [PHASE_FRACTION_BITS+SINE_ADDR_BITS:0] scaled;
		logic [SINE_ADDR_BITS-1:0]                   idx;
		logic [1:0]                                  quad;
		logic [QUARTER_BITS-1:0]                     rem;
		logic [QUARTER_BITS:0]                       fold;

		// phase * depth + half lsb, then keep the integer part mod depth
		assign scaled = {1'b0, ph_phase_s[c], {SINE_ADDR_BITS{1'b0}}}
		              + ((PHASE_FRACTION_BITS + SINE_ADDR_BITS + 1)'(1)
		                 << (PHASE_FRACTION_BITS - 1));
		assign idx    = scaled[PHASE_FRACTION_BITS +: SINE_ADDR_BITS];
		assign quad   = idx[SINE_ADDR_BITS-1 -: 2];
		assign rem    = idx[QUARTER_BITS-1:0];
		// second and fourth quarters run the quarter wave backwards
		assign fold   = quad[0] ? ((QUARTER_BITS + 1)'(QUARTER_DEPTH) - {1'b0, rem})
		                        : {1'b0, rem};

		assign ad_addr_nx[c] = fold[QUARTER_BITS-1:0];
		assign ad_peak_nx[c] = fold[QUARTER_BITS];
		assign ad_neg_nx[c]  = quad[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ad_vld_s <= 1'b0;
		else if (adv)
			ad_vld_s <= ph_vld_s;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ad_blk_s <= ph_blk_s;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				ad_addr_s[c] <= ad_addr_nx[c];
				ad_neg_s[c]  <= ad_neg_nx[c];
				ad_peak_s[c] <= ad_peak_nx[c];
			end
		end
	end

	// ------------------------------------------------------------------
	// color stage: table lookup into the output register
	// ------------------------------------------------------------------
	color_t                  chan [NUM_CHANNELS];
	logic [PIXEL_BITS-1:0]   col_pix_s;

	always_comb begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (ad_peak_s[c])
				chan[c] = ad_neg_s[c] ? SINE_NEG_PEAK : SINE_POS_PEAK;
			else if (ad_neg_s[c])
				chan[c] = SINE_NEG_ROM[ad_addr_s[c]];
			else
				chan[c] = SINE_POS_ROM[ad_addr_s[c]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			col_vld_s <= 1'b0;
		else if (adv)
			col_vld_s <= ad_vld_s;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// red high byte, blue low byte; interior is black
			col_pix_s <= ad_blk_s ? '0 : {chan[0], chan[1], chan[2]};
		end
	end

	assign out_valid   = col_vld_s;
	assign pixel_color = col_pix_s;

endmodule
